/* rtl/core/compressor_cycle_guard_assert.svh */
// Assertion macros for the compressor cycle guard checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef COMPRESSOR_CYCLE_GUARD_ASSERT_SVH
`define COMPRESSOR_CYCLE_GUARD_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define CCG_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ccg_pkg.sv */
// Shared types and constants for the compressor cycle guard.
// No dependencies; imported by every module of the block.
package ccg_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] MODE_READY = 2'd0;
   localparam logic [1:0] MODE_REST  = 2'd1;
   localparam logic [1:0] MODE_WORK  = 2'd2;
   localparam logic [1:0] MODE_WAIT  = 2'd3;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   localparam logic [2:0] REG_START_TEMP = 3'd0;
   localparam logic [2:0] REG_STOP_TEMP  = 3'd1;
   localparam logic [2:0] REG_MAX_RUN    = 3'd2;
   localparam logic [2:0] REG_REST       = 3'd3;
   localparam logic [2:0] REG_WAIT       = 3'd4;

   typedef struct packed {
      logic       compressor_on;
      logic [1:0] mode;
      logic       request_temperature;
   } rsp_payload_type;

endpackage

/* rtl/core/ccg_if.sv */
// Valid/ready channel interfaces for sample/tick requests and responses.
// Depends on nothing; used by compressor_cycle_guard ports.
interface ccg_req_if #(
   parameter int TEMP_BITS = 12
);
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic signed [TEMP_BITS-1:0] temperature;
   logic                        temperature_fault;

   modport source (output valid, req_type, temperature, temperature_fault, input ready);
   modport sink   (input valid, req_type, temperature, temperature_fault, output ready);
endinterface

interface ccg_rsp_if;
   logic       valid;
   logic       ready;
   logic       compressor_on;
   logic [1:0] mode;
   logic       request_temperature;

   modport source (output valid, compressor_on, mode, request_temperature, input ready);
   modport sink   (input valid, compressor_on, mode, request_temperature, output ready);
endinterface

/* rtl/core/compressor_cycle_guard.sv */
// Compressor thermostat with anti-short-cycle timers; input register,
// one update stage and a result register. The response is registered in the result
// register. Throughput: one transaction per cycle while the response side accepts.
// Synchronous active-high reset: mode ready, timer stopped, power off,
// pipeline empty, registers at their documented defaults. No clearing pass.
module compressor_cycle_guard #(
   parameter int TIMER_BITS = 24,
   parameter int TEMP_BITS  = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   ccg_req_if.sink                           req_bus,
   ccg_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ccg_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [ccg_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [ccg_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import ccg_pkg::*;

   logic signed [TEMP_BITS-1:0] start_temp, stop_temp;
   logic [TIMER_BITS-1:0]       max_run_ticks, rest_ticks, wait_ticks;

   logic                        in_valid_ff;
   logic                        in_type_ff;
   logic signed [TEMP_BITS-1:0] in_temp_ff;
   logic                        in_fault_ff;
   logic                        out_valid_ff;
   rsp_payload_type             out_data_ff;
   rsp_payload_type             step_result;
   logic                        out_open, in_open, fire;

   assign out_open = !out_valid_ff || rsp_bus.ready;
   assign fire     = in_valid_ff && out_open;
   assign in_open  = !in_valid_ff || out_open;
   assign req_bus.ready = in_open;

   ccg_csr #(.TIMER_BITS(TIMER_BITS), .TEMP_BITS(TEMP_BITS)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .start_temp    (start_temp),
      .stop_temp     (stop_temp),
      .max_run_ticks (max_run_ticks),
      .rest_ticks    (rest_ticks),
      .wait_ticks    (wait_ticks)
   );

   ccg_step #(.TIMER_BITS(TIMER_BITS), .TEMP_BITS(TEMP_BITS)) u_step (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .req_type          (in_type_ff),
      .temperature       (in_temp_ff),
      .temperature_fault (in_fault_ff),
      .start_temp        (start_temp),
      .stop_temp         (stop_temp),
      .max_run_ticks     (max_run_ticks),
      .rest_ticks        (rest_ticks),
      .wait_ticks        (wait_ticks),
      .result            (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_open) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_open && req_bus.valid) begin
         in_type_ff  <= req_bus.req_type;
         in_temp_ff  <= req_bus.temperature;
         in_fault_ff <= req_bus.temperature_fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_bus.valid               = out_valid_ff;
   assign rsp_bus.compressor_on       = out_data_ff.compressor_on;
   assign rsp_bus.mode                = out_data_ff.mode;
   assign rsp_bus.request_temperature = out_data_ff.request_temperature;

endmodule

/* rtl/core/ccg_csr.sv */
// APB-style configuration registers: thresholds and timer reloads.
// Depends on ccg_pkg.
module ccg_csr #(
   parameter int TIMER_BITS = 24,
   parameter int TEMP_BITS  = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ccg_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ccg_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ccg_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output logic signed [TEMP_BITS-1:0]         start_temp,
   output logic signed [TEMP_BITS-1:0]         stop_temp,
   output logic [TIMER_BITS-1:0]               max_run_ticks,
   output logic [TIMER_BITS-1:0]               rest_ticks,
   output logic [TIMER_BITS-1:0]               wait_ticks
);
   import ccg_pkg::*;

   logic signed [TEMP_BITS-1:0] start_ff, stop_ff;
   logic [TIMER_BITS-1:0]       max_run_ff, rest_ff, wait_ff;
   logic                        wr_en;
   logic [2:0]                  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= TEMP_BITS'(50);
         stop_ff    <= TEMP_BITS'(20);
         max_run_ff <= TIMER_BITS'(32'd3600000);
         rest_ff    <= TIMER_BITS'(32'd600000);
         wait_ff    <= TIMER_BITS'(32'd300000);
      end else if (wr_en) begin
         case (reg_idx)
            REG_START_TEMP: start_ff   <= pwdata[TEMP_BITS-1:0];
            REG_STOP_TEMP:  stop_ff    <= pwdata[TEMP_BITS-1:0];
            REG_MAX_RUN:    max_run_ff <= pwdata[TIMER_BITS-1:0];
            REG_REST:       rest_ff    <= pwdata[TIMER_BITS-1:0];
            REG_WAIT:       wait_ff    <= pwdata[TIMER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_TEMP: prdata = CSR_DATA_BITS'(start_ff);
         REG_STOP_TEMP:  prdata = CSR_DATA_BITS'(stop_ff);
         REG_MAX_RUN:    prdata = CSR_DATA_BITS'(max_run_ff);
         REG_REST:       prdata = CSR_DATA_BITS'(rest_ff);
         REG_WAIT:       prdata = CSR_DATA_BITS'(wait_ff);
         default:        prdata = '0;
      endcase
   end

   assign start_temp    = start_ff;
   assign stop_temp     = stop_ff;
   assign max_run_ticks = max_run_ff;
   assign rest_ticks    = rest_ff;
   assign wait_ticks    = wait_ff;

endmodule

/* rtl/core/ccg_step.sv */
// Mode, timer and power state with the per-transaction update logic.
// Depends on ccg_pkg.
module ccg_step #(
   parameter int TIMER_BITS = 24,
   parameter int TEMP_BITS  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic                         req_type,
   input  logic signed [TEMP_BITS-1:0]  temperature,
   input  logic                         temperature_fault,
   input  logic signed [TEMP_BITS-1:0]  start_temp,
   input  logic signed [TEMP_BITS-1:0]  stop_temp,
   input  logic [TIMER_BITS-1:0]        max_run_ticks,
   input  logic [TIMER_BITS-1:0]        rest_ticks,
   input  logic [TIMER_BITS-1:0]        wait_ticks,
   output ccg_pkg::rsp_payload_type     result
);
   import ccg_pkg::*;

   logic [1:0]            mode_ff, mode_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  power_ff, power_in;
   logic                  request;
   logic [TIMER_BITS-1:0] max_load, rest_load, wait_load, timer_dec;

   // a zero reload expires on the next tick
   assign max_load  = (max_run_ticks == '0) ? TIMER_BITS'(1) : max_run_ticks;
   assign rest_load = (rest_ticks == '0) ? TIMER_BITS'(1) : rest_ticks;
   assign wait_load = (wait_ticks == '0) ? TIMER_BITS'(1) : wait_ticks;
   assign timer_dec = timer_ff - TIMER_BITS'(1);

   always_comb begin
      mode_in  = mode_ff;
      timer_in = timer_ff;
      power_in = power_ff;
      request  = 1'b0;
      if (req_type == REQ_SAMPLE) begin
         if (temperature_fault) begin
            if (mode_ff != MODE_READY) begin
               mode_in  = MODE_READY;
               timer_in = '0;
               power_in = 1'b0;
            end
         end else if (temperature >= start_temp && mode_ff == MODE_READY) begin
            power_in = 1'b1;
            mode_in  = MODE_WORK;
            timer_in = max_load;
         end else if (temperature <= stop_temp && mode_ff == MODE_WORK) begin
            power_in = 1'b0;
            mode_in  = MODE_WAIT;
            timer_in = wait_load;
         end
      end else if (timer_ff != '0) begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            if (mode_ff == MODE_WORK) begin
               power_in = 1'b0;
               mode_in  = MODE_REST;
               timer_in = rest_load;
            end else begin
               mode_in = MODE_READY;
               request = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_READY;
         timer_ff <= '0;
         power_ff <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         timer_ff <= timer_in;
         power_ff <= power_in;
      end
   end

   assign result.compressor_on       = power_in;
   assign result.mode                = mode_in;
   assign result.request_temperature = request;

endmodule

/* rtl/core/ccg_checker.sv */
// Port-level checks on the response channel of compressor_cycle_guard.
// Depends on ccg_pkg and compressor_cycle_guard_assert.svh; bound to the top.
`include "compressor_cycle_guard_assert.svh"

module ccg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       compressor_on,
   input logic [1:0] mode,
   input logic       request_temperature
);
   import ccg_pkg::*;

   `CCG_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(compressor_on) && $stable(mode) && $stable(request_temperature), "response changed while stalled")
   `CCG_ASSERT_RST(a_power_work, clock, reset, rsp_valid |-> (compressor_on == (mode == MODE_WORK)), "power does not match work mode")
   `CCG_ASSERT_RST(a_request_ready, clock, reset, rsp_valid && request_temperature |-> mode == MODE_READY, "request raised outside ready")
   `CCG_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind compressor_cycle_guard ccg_checker u_ccg_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .compressor_on       (rsp_bus.compressor_on),
   .mode                (rsp_bus.mode),
   .request_temperature (rsp_bus.request_temperature)
);

/* test/tb_compressor_cycle_guard.sv */
// Testbench for compressor_cycle_guard: directed table, then random samples and ticks
// under several threshold/timer settings, checked against a thermostat predictor.
// Depends on ccg_pkg, ccg_req_if/ccg_rsp_if and the compressor_cycle_guard RTL.
module tb_compressor_cycle_guard;
   timeunit 1ns;
   timeprecision 1ps;
   import ccg_pkg::*;

   localparam int TICK_BITS       = 24;
   localparam int SAMPLE_BITS     = 12;
   localparam int DIRECTED_COUNT  = 25;
   localparam int SHORT_TIMER_ROW = 12;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 285;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 200;
   localparam int HOLD_AFTER      = 500;

   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] temp;
      logic                          fault;
      logic                          fixed;
      rsp_payload_type               status;
   } stim_row_type;

   localparam rsp_payload_type IDLE_STATUS    = '{1'b0, MODE_READY, 1'b0};
   localparam rsp_payload_type RUN_STATUS     = '{1'b1, MODE_WORK, 1'b0};
   localparam rsp_payload_type RELEASE_STATUS = '{1'b0, MODE_READY, 1'b1};
   localparam rsp_payload_type NO_STATUS      = '0;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   ccg_req_if #(.TEMP_BITS(SAMPLE_BITS)) req_bus ();
   ccg_rsp_if rsp_bus ();

   compressor_cycle_guard #(.TIMER_BITS(TICK_BITS), .TEMP_BITS(SAMPLE_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // thermostat shadow state and settings
   logic signed [SAMPLE_BITS-1:0] cfg_start;
   logic signed [SAMPLE_BITS-1:0] cfg_stop;
   logic [TICK_BITS-1:0]          cfg_max_run;
   logic [TICK_BITS-1:0]          cfg_rest;
   logic [TICK_BITS-1:0]          cfg_wait;
   logic [1:0]                    pred_mode;
   logic [TICK_BITS-1:0]          pred_timer;
   logic                          pred_power;

   rsp_payload_type pending_status_q[$];
   stim_row_type    directed_rows [DIRECTED_COUNT];
   int              mismatch_count  = 0;
   int              delivered_count = 0;
   int              burst_left      = 0;
   bit              sender_idles    = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   task automatic reset_thermostat();
      cfg_start   = 12'sd50;
      cfg_stop    = 12'sd20;
      cfg_max_run = 24'd3600000;
      cfg_rest    = 24'd600000;
      cfg_wait    = 24'd300000;
      pred_mode   = MODE_READY;
      pred_timer  = '0;
      pred_power  = 1'b0;
   endtask

   function automatic logic [TICK_BITS-1:0] timer_load(input logic [TICK_BITS-1:0] ticks);
      return (ticks == '0) ? TICK_BITS'(1) : ticks;
   endfunction

   task automatic advance_thermostat(input logic kind, input logic signed [SAMPLE_BITS-1:0] temp,
                                     input logic fault, output rsp_payload_type status);
      status.request_temperature = 1'b0;
      if (kind == REQ_SAMPLE) begin
         if (fault) begin
            if (pred_mode != MODE_READY) begin
               pred_mode  = MODE_READY;
               pred_timer = '0;
               pred_power = 1'b0;
            end
         end else if (temp >= cfg_start && pred_mode == MODE_READY) begin
            pred_power = 1'b1;
            pred_mode  = MODE_WORK;
            pred_timer = timer_load(cfg_max_run);
         end else if (temp <= cfg_stop && pred_mode == MODE_WORK) begin
            pred_power = 1'b0;
            pred_mode  = MODE_WAIT;
            pred_timer = timer_load(cfg_wait);
         end
      end else if (pred_timer != '0) begin
         pred_timer = pred_timer - TICK_BITS'(1);
         if (pred_timer == '0) begin
            if (pred_mode == MODE_WORK) begin
               pred_power = 1'b0;
               pred_mode  = MODE_REST;
               pred_timer = timer_load(cfg_rest);
            end else begin
               pred_mode                  = MODE_READY;
               status.request_temperature = 1'b1;
            end
         end
      end
      status.compressor_on = pred_power;
      status.mode          = pred_mode;
   endtask

   // leaves psel high so that back-to-back writes need no idle state between them
   task automatic csr_write(input logic [2:0] index, input logic [CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_START_TEMP: cfg_start   = value[SAMPLE_BITS-1:0];
         REG_STOP_TEMP:  cfg_stop    = value[SAMPLE_BITS-1:0];
         REG_MAX_RUN:    cfg_max_run = value[TICK_BITS-1:0];
         REG_REST:       cfg_rest    = value[TICK_BITS-1:0];
         REG_WAIT:       cfg_wait    = value[TICK_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [31:0] start_word, stop_word, run_word,
                                 rest_word, wait_word);
      csr_write(REG_START_TEMP, start_word);
      csr_write(REG_STOP_TEMP, stop_word);
      csr_write(REG_MAX_RUN, run_word);
      csr_write(REG_REST, rest_word);
      csr_write(REG_WAIT, wait_word);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic offer_item(input stim_row_type row, input bit keep_valid);
      rsp_payload_type status;
      req_bus.valid             <= 1'b1;
      req_bus.req_type          <= row.kind;
      req_bus.temperature       <= row.temp;
      req_bus.temperature_fault <= row.fault;
      do @(posedge clock); while (!req_bus.ready);
      advance_thermostat(row.kind, row.temp, row.fault, status);
      pending_status_q.push_back(row.fixed ? row.status : status);
      if (!keep_valid) req_bus.valid <= 1'b0;
   endtask

   task automatic next_gap(output int gap);
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if (sender_idles) gap = $urandom_range(1, 8);
      end
   endtask

   task automatic wait_drained();
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // half ticks, and samples mostly close to the thresholds so that work/wait/rest are all reached
   task automatic random_row(output stim_row_type row);
      int pick;
      int offset;
      pick       = $urandom_range(0, 99);
      offset     = int'($urandom_range(0, 6)) - 3;
      row.fixed  = 1'b0;
      row.status = NO_STATUS;
      row.kind   = (pick < 50) ? REQ_TICK : REQ_SAMPLE;
      row.fault  = ($urandom_range(0, 15) == 0);
      row.temp   = SAMPLE_BITS'($urandom);
      if (pick >= 50 && pick < 75) row.temp = SAMPLE_BITS'(cfg_start + offset);
      else if (pick >= 75 && pick < 95) row.temp = SAMPLE_BITS'(cfg_stop + offset);
   endtask

   initial begin : response_check
      int              cycle_count;
      int              hold_left;
      bit              held;
      rsp_payload_type want;
      cycle_count = 0;
      hold_left   = 0;
      held        = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            delivered_count++;
            if (pending_status_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected response: on=%b mode=%0d req=%b", rsp_bus.compressor_on,
                           rsp_bus.mode, rsp_bus.request_temperature);
               mismatch_count++;
            end else begin
               want = pending_status_q.pop_front();
               if (rsp_bus.compressor_on !== want.compressor_on || rsp_bus.mode !== want.mode ||
                   rsp_bus.request_temperature !== want.request_temperature) begin
                  if (mismatch_count < 10)
                     $display("transaction %0d: expected on=%b mode=%0d req=%b, got on=%b mode=%0d req=%b",
                              delivered_count, want.compressor_on, want.mode,
                              want.request_temperature, rsp_bus.compressor_on, rsp_bus.mode,
                              rsp_bus.request_temperature);
                  mismatch_count++;
               end
            end
         end
         cycle_count++;
         if (!held && delivered_count >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((cycle_count / 256) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               2: rsp_bus.ready <= (cycle_count % 5 != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   initial begin : stimulus
      int              gap;
      int              start_val;
      int              stop_val;
      stim_row_type    row;
      logic [31:0]     junk;
      directed_rows = '{
         '{REQ_TICK,   12'h000, 1'b0, 1'b1, IDLE_STATUS},
         '{REQ_SAMPLE, 12'h7FF, 1'b1, 1'b1, IDLE_STATUS},
         '{REQ_SAMPLE, 12'h800, 1'b0, 1'b1, IDLE_STATUS},
         '{REQ_SAMPLE, 12'h7FF, 1'b0, 1'b1, RUN_STATUS},
         '{REQ_SAMPLE, 12'h7FF, 1'b0, 1'b0, NO_STATUS},
         '{REQ_TICK,   12'hFFF, 1'b1, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'h800, 1'b1, 1'b1, IDLE_STATUS},
         '{REQ_SAMPLE, 12'd50,  1'b0, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'd21,  1'b0, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'd20,  1'b0, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'h7FF, 1'b0, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'h000, 1'b1, 1'b1, IDLE_STATUS},
         '{REQ_SAMPLE, 12'h000, 1'b0, 1'b1, RUN_STATUS},
         '{REQ_TICK,   12'h000, 1'b0, 1'b0, NO_STATUS},
         '{REQ_TICK,   12'h000, 1'b0, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'h7FF, 1'b0, 1'b0, NO_STATUS},
         '{REQ_TICK,   12'h000, 1'b0, 1'b1, RELEASE_STATUS},
         '{REQ_SAMPLE, 12'd5,   1'b0, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'hFFF, 1'b0, 1'b0, NO_STATUS},
         '{REQ_TICK,   12'h000, 1'b0, 1'b0, NO_STATUS},
         '{REQ_TICK,   12'h000, 1'b0, 1'b1, IDLE_STATUS},
         '{REQ_SAMPLE, 12'h000, 1'b0, 1'b0, NO_STATUS},
         '{REQ_TICK,   12'h000, 1'b0, 1'b0, NO_STATUS},
         '{REQ_TICK,   12'h000, 1'b0, 1'b0, NO_STATUS},
         '{REQ_SAMPLE, 12'h7FF, 1'b1, 1'b1, IDLE_STATUS}
      };
      reset                     <= 1'b1;
      psel                      <= 1'b0;
      penable                   <= 1'b0;
      pwrite                    <= 1'b0;
      paddr                     <= '0;
      pwdata                    <= '0;
      req_bus.valid             <= 1'b0;
      req_bus.req_type          <= REQ_SAMPLE;
      req_bus.temperature       <= '0;
      req_bus.temperature_fault <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      reset_thermostat();

      // reset thresholds first, then short timers with a zero wait load
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (i == SHORT_TIMER_ROW) begin
            wait_drained();
            apply_settings(32'd0, 32'd0, 32'd2, 32'd1, 32'd0);
         end
         next_gap(gap);
         offer_item(directed_rows[i],
                    gap == 0 && i != SHORT_TIMER_ROW - 1 && i != DIRECTED_COUNT - 1);
         repeat (gap) @(posedge clock);
      end
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_settings(32'h7FF, 32'hFFFF_F800, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF);
            1: apply_settings(32'hFFFF_F800, 32'h7FF, 32'd1, 32'd1, 32'd1);
            default: begin
               start_val = int'($urandom_range(0, 400)) - 200;
               stop_val  = start_val - int'($urandom_range(0, 40));
               junk      = $urandom;
               // upper bits above the register width are don't-care
               apply_settings({junk[31:12], 12'(start_val)}, {junk[19:0], 12'(stop_val)},
                              {junk[7:0], 24'($urandom_range(1, 6))},
                              {junk[15:8], 24'($urandom_range(1, 6))},
                              {junk[23:16], 24'($urandom_range(1, 6))});
            end
         endcase
         sender_idles = (p != 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            random_row(row);
            next_gap(gap);
            offer_item(row, gap == 0 && n != ITEMS_PER_PHASE - 1);
            repeat (gap) @(posedge clock);
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
